@@ rtl/assert_macros.svh @@
// assertion helper macros shared by the rtl files
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPAW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SPAW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/spaw_pkg.sv @@
// shared types and constants for the scaled phase angle wrap block
// no dependencies
`default_nettype none

package spaw_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ANGLE_STAGES_DEF = 16;
  localparam int TABLE_LEN        = 24;

  localparam int GAIN_W   = 12;
  localparam int MARKER_W = 16;
  localparam int ANGLE_W  = 16;
  localparam int TURN_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = 12'd691;
  localparam logic [MARKER_W-1:0] MARKER_RST = 16'h8000;

  // round(2pi * 2^29), turns to q3.13 radians after >> 48
  localparam logic [TURN_W-1:0] TWO_PI_K = 32'd3373259426;
  localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'd51471;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic [TURN_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAG_GAIN      = 2'd0,
    REG_INVALID_MARKER = 2'd1
  } spaw_reg_t;

  // control that travels alongside each item
  typedef struct packed {
    logic vld;
    logic hold;
    logic no_data;
  } spaw_ctl_t;

endpackage

`default_nettype wire

@@ rtl/spaw_front.sv @@
// input stages: gain multiply, marker compare, then quadrant pre-rotation
// depends on spaw_pkg
`default_nettype none

module spaw_front #(
  parameter int SW = 16,
  parameter int W  = 30
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 acc_i,
  input  wire  signed [SW-1:0]                p_i,
  input  wire  signed [SW-1:0]                a_i,
  input  wire  [spaw_pkg::GAIN_W-1:0]         gain_i,
  input  wire  signed [spaw_pkg::MARKER_W-1:0] marker_i,
  output spaw_pkg::spaw_ctl_t                 ctl_o,
  output logic signed [W-1:0]                 x_o,
  output logic signed [W-1:0]                 y_o,
  output logic [spaw_pkg::TURN_W-1:0]         z_o
);
  import spaw_pkg::*;

  localparam int CW = (SW > MARKER_W) ? SW : MARKER_W;
  localparam int PW = SW + GAIN_W + 1;

  logic signed [CW-1:0] pe, ae, me;
  logic signed [PW-1:0] prod;
  logic signed [W-1:0]  xa_r, ya_r;
  spaw_ctl_t            ca_r;
  logic                 x_neg, y_zero;

  // stage a: scale both parts into 1/256 units, spot the no-data marker
  assign pe = CW'(p_i);
  assign ae = CW'(a_i);
  assign me = CW'(marker_i);
  assign prod = a_i * $signed({1'b0, gain_i});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= '0;
    end else begin
      ca_r.vld     <= acc_i;
      ca_r.no_data <= (pe == me) && (ae == me);
      ca_r.hold    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    xa_r <= W'($signed({p_i, 8'b0}));
    ya_r <= W'(prod);
  end

  // stage b: fold left half plane onto the right, pin the zero-imag case
  assign x_neg  = xa_r[W-1];
  assign y_zero = (ya_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else begin
      ctl_o.vld     <= ca_r.vld;
      ctl_o.no_data <= ca_r.no_data;
      ctl_o.hold    <= y_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (y_zero) begin
      x_o <= xa_r;
      y_o <= ya_r;
      z_o <= x_neg ? HALF_TURN : '0;
    end else if (x_neg) begin
      x_o <= -xa_r;
      y_o <= -ya_r;
      z_o <= HALF_TURN;
    end else begin
      x_o <= xa_r;
      y_o <= ya_r;
      z_o <= '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/spaw_cell.sv @@
// one cordic vectoring micro-rotation with its pipeline register
// depends on spaw_pkg and assert_macros.svh
`default_nettype none

module spaw_cell #(
  parameter int W   = 30,
  parameter int IDX = 0
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  spaw_pkg::spaw_ctl_t         ctl_i,
  input  wire  signed [W-1:0]         x_i,
  input  wire  signed [W-1:0]         y_i,
  input  wire  [spaw_pkg::TURN_W-1:0] z_i,
  output spaw_pkg::spaw_ctl_t         ctl_o,
  output logic signed [W-1:0]         x_o,
  output logic signed [W-1:0]         y_o,
  output logic [spaw_pkg::TURN_W-1:0] z_o
);
  import spaw_pkg::*;
  `include "assert_macros.svh"

  localparam logic [TURN_W-1:0] STEP = ATAN_TURNS[IDX];

  logic signed [W-1:0] xs, ys;

  // fixed arithmetic shifts for this stage
  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  // rotate toward the real axis unless the angle is already settled
  always_ff @(posedge clk) begin
    if (ctl_i.hold) begin
      x_o <= x_i;
      y_o <= y_i;
      z_o <= z_i;
    end else if (!y_i[W-1]) begin
      x_o <= x_i + ys;
      y_o <= y_i - xs;
      z_o <= z_i + STEP;
    end else begin
      x_o <= x_i - ys;
      y_o <= y_i + xs;
      z_o <= z_i - STEP;
    end
  end

  `SPAW_ASSERT_NEXT(a_hold_keeps_z, ctl_i.vld && ctl_i.hold, z_o == $past(z_i), "held angle changed")

endmodule

`default_nettype wire

@@ rtl/spaw_scale.sv @@
// turns-to-radians conversion and output register
// depends on spaw_pkg and assert_macros.svh
`default_nettype none

module spaw_scale (
  input  wire                          clk,
  input  wire                          rst_n,
  input  spaw_pkg::spaw_ctl_t          ctl_i,
  input  wire  [spaw_pkg::TURN_W-1:0]  z_i,
  output logic                         vld_o,
  output logic [spaw_pkg::ANGLE_W-1:0] angle_o,
  output logic                         no_data_o
);
  import spaw_pkg::*;
  `include "assert_macros.svh"

  logic [2*TURN_W-1:0] prod_r;
  spaw_ctl_t           ctl_r;

  // multiply by 2pi scaled, keep the top bits next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= z_i * TWO_PI_K;
  end

  // output register, marker hits read as zero angle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o     <= 1'b0;
      no_data_o <= 1'b0;
    end else begin
      vld_o     <= ctl_r.vld;
      no_data_o <= ctl_r.no_data;
    end
  end

  always_ff @(posedge clk) begin
    angle_o <= ctl_r.no_data ? '0 : prod_r[2*TURN_W-1 -: ANGLE_W];
  end

  `SPAW_ASSERT_IMPL(a_angle_range, vld_o, angle_o <= ANGLE_MAX, "angle beyond 2pi")

endmodule

`default_nettype wire

@@ rtl/scaled_phase_angle_wrap_core.sv @@
// top level of the scaled phase angle wrap block
// depends on spaw_pkg, spaw_front, spaw_cell, spaw_scale, assert_macros.svh
//
// Usage:
//   A sample pair is taken on in_phase_sample / in_amp_sample at every clock
//   edge where start is high and busy is low. The block returns the argument
//   of (phase, amp * imag_gain) wrapped into [0, 2pi) as unsigned q3.13 on
//   out_angle, with out_no_data set (and angle 0) when both samples equal the
//   marker. Each result shows for one cycle with out_valid high.
//   The pipeline holds two input stages, one cell per cordic micro-rotation
//   (ANGLE_STAGES cells, capped at 24), a multiply stage and the output
//   register. One pair is taken every cycle while busy is low; results come
//   back in order at that rate. The receiver cannot stall, so no backpressure.
//   Configuration writes transfer on cfg_valid && cfg_ready, ready is always
//   high; index 0 is imag_gain, index 1 is invalid_marker.
//   Reset (synchronous, rst_n low) flushes the pipeline, restores gain 691
//   and marker -32768, and holds busy high until the cycle after release.
`default_nettype none

module scaled_phase_angle_wrap_core #(
  parameter int SAMPLE_WIDTH = spaw_pkg::SAMPLE_WIDTH_DEF,
  parameter int ANGLE_STAGES = spaw_pkg::ANGLE_STAGES_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  output logic                                 busy,
  input  wire  signed [SAMPLE_WIDTH-1:0]       in_phase_sample,
  input  wire  signed [SAMPLE_WIDTH-1:0]       in_amp_sample,
  output logic                                 out_valid,
  output logic [spaw_pkg::ANGLE_W-1:0]         out_angle,
  output logic                                 out_no_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [spaw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [spaw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import spaw_pkg::*;
  `include "assert_macros.svh"

  localparam int CELLS = (ANGLE_STAGES < TABLE_LEN) ? ANGLE_STAGES : TABLE_LEN;
  localparam int W     = SAMPLE_WIDTH + 14;
  localparam int LAT   = CELLS + 4;

  logic                       busy_r;
  logic [GAIN_W-1:0]          gain_r;
  logic signed [MARKER_W-1:0] marker_r;
  logic                       in_acc;

  spaw_ctl_t           ctl   [CELLS+1];
  logic signed [W-1:0] xv    [CELLS+1];
  logic signed [W-1:0] yv    [CELLS+1];
  logic [TURN_W-1:0]   zv    [CELLS+1];

  // busy only while in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign in_acc    = start && !busy_r;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RST;
      marker_r <= MARKER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAG_GAIN:      gain_r   <= cfg_wdata[GAIN_W-1:0];
        REG_INVALID_MARKER: marker_r <= cfg_wdata[MARKER_W-1:0];
        default: ;
      endcase
    end
  end

  spaw_front #(
    .SW (SAMPLE_WIDTH),
    .W  (W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_i    (in_acc),
    .p_i      (in_phase_sample),
    .a_i      (in_amp_sample),
    .gain_i   (gain_r),
    .marker_i (marker_r),
    .ctl_o    (ctl[0]),
    .x_o      (xv[0]),
    .y_o      (yv[0]),
    .z_o      (zv[0])
  );

  // chain of micro-rotation cells
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    spaw_cell #(
      .W   (W),
      .IDX (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl[g]),
      .x_i   (xv[g]),
      .y_i   (yv[g]),
      .z_i   (zv[g]),
      .ctl_o (ctl[g+1]),
      .x_o   (xv[g+1]),
      .y_o   (yv[g+1]),
      .z_o   (zv[g+1])
    );
  end

  spaw_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl[CELLS]),
    .z_i       (zv[CELLS]),
    .vld_o     (out_valid),
    .angle_o   (out_angle),
    .no_data_o (out_no_data)
  );

  `SPAW_ASSERT_IMPL(a_strobe_on_time, out_valid, $past(in_acc, LAT), "result strobe off schedule")
  `SPAW_ASSERT_IMPL(a_result_follows, $past(in_acc, LAT), out_valid, "result strobe missing")
  `SPAW_ASSERT_IMPL(a_no_data_zero, out_valid && out_no_data, out_angle == '0, "marker result not zero")

endmodule

`default_nettype wire

@@ tb/sv/scaled_phase_angle_wrap_core_test.sv @@
// self-checking bench for scaled_phase_angle_wrap_core: directed and random sample pairs
// under several gain and marker settings, checked against a cordic angle predictor
// depends on spaw_pkg and the rtl of scaled_phase_angle_wrap_core
module scaled_phase_angle_wrap_core_test;
  import spaw_pkg::*;

  localparam int CORDIC_STAGES = 16;
  localparam int PIPE_LATENCY  = CORDIC_STAGES + 4;
  localparam int STALL_LIMIT   = 4000;
  localparam int REPORT_LIMIT  = 10;

  // turns (2^32 per revolution) to q3.13 radians after >> 48
  localparam logic [31:0] TURN_TO_RAD = 32'd3373259426;
  localparam logic [31:0] HALF_REV    = 32'h8000_0000;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic [31:0] ATAN_STEP_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [15:0] phase;
    logic signed [15:0] amp;
  } sample_pair_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               no_data;
  } angle_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic signed [15:0]    in_phase_sample = '0;
  logic signed [15:0]    in_amp_sample = '0;
  logic                  out_valid;
  logic [ANGLE_W-1:0]    out_angle;
  logic                  out_no_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAG_GAIN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // register copies as seen by the block
  logic [11:0]   gain_now = 12'd691;
  logic [15:0]   marker_now = 16'h8000;

  sample_pair_t  pair_q[$];
  angle_result_t angle_q[$];
  sample_pair_t  next_pair;
  angle_result_t want;
  logic          pair_taken = 1'b0;
  logic          cfg_taken = 1'b0;
  int            idle_pct = 0;
  int            mismatch_count = 0;
  int            stall_cycles = 0;

  scaled_phase_angle_wrap_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_phase_sample (in_phase_sample),
    .in_amp_sample   (in_amp_sample),
    .out_valid       (out_valid),
    .out_angle       (out_angle),
    .out_no_data     (out_no_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // wrapped argument of (phase * 256, amp * gain) by vectoring cordic
  function automatic angle_result_t predict_angle(sample_pair_t pair, logic [11:0] gain,
                                                  logic [15:0] marker);
    angle_result_t res;
    longint        re;
    longint        im;
    longint        re_sh;
    longint        im_sh;
    logic [31:0]   turns;
    logic [63:0]   scaled;
    int            i;
    res = '0;
    if (pair.phase == marker && pair.amp == marker) begin
      res.no_data = 1'b1;
      return res;
    end
    re = longint'($signed(pair.phase)) * 256;
    im = longint'($signed(pair.amp)) * longint'({1'b0, gain});
    turns = '0;
    if (im == 0) begin
      // on the real axis, sign of zero is not kept
      turns = (re < 0) ? HALF_REV : 32'd0;
    end else begin
      // left half plane: rotate by half a turn first
      if (re < 0) begin
        re = -re;
        im = -im;
        turns = HALF_REV;
      end
      for (i = 0; i < CORDIC_STAGES; i++) begin
        re_sh = re >>> i;
        im_sh = im >>> i;
        if (im >= 0) begin
          re = re + im_sh;
          im = im - re_sh;
          turns = turns + ATAN_STEP_TURNS[i];
        end else begin
          re = re - im_sh;
          im = im + re_sh;
          turns = turns - ATAN_STEP_TURNS[i];
        end
      end
    end
    // modulo 2^32 accumulation already wraps negative angles into [0, 2pi)
    scaled = {32'd0, turns} * {32'd0, TURN_TO_RAD};
    res.angle = scaled[63:48];
    return res;
  endfunction

  // sample pair driver, inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !pair_taken) begin
      // hold the pair until its transfer
    end else if (pair_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
      next_pair = pair_q.pop_front();
      start <= 1'b1;
      in_phase_sample <= next_pair.phase;
      in_amp_sample <= next_pair.amp;
    end else begin
      start <= 1'b0;
      in_phase_sample <= 16'($urandom);
      in_amp_sample <= 16'($urandom);
    end
  end

  // monitor: predict on input transfer, check on each result strobe
  always @(posedge clk) begin
    if (!rst_n) begin
      pair_taken <= 1'b0;
      cfg_taken <= 1'b0;
      stall_cycles <= 0;
    end else begin
      pair_taken <= start && !busy;
      cfg_taken <= cfg_valid && cfg_ready;
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAG_GAIN:      gain_now = cfg_wdata[11:0];
          REG_INVALID_MARKER: marker_now = cfg_wdata;
          default: ;
        endcase
      end

      if (start && !busy)
        angle_q.push_back(predict_angle(sample_pair_t'{phase: in_phase_sample,
                                                       amp: in_amp_sample},
                                        gain_now, marker_now));

      if (out_valid) begin
        if (angle_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result: angle=%0d no_data=%0b", out_angle, out_no_data);
        end else begin
          want = angle_q.pop_front();
          if (out_angle !== want.angle || out_no_data !== want.no_data) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("mismatch: angle exp=%0d got=%0d, no_data exp=%0b got=%0b",
                       want.angle, out_angle, want.no_data, out_no_data);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer of any kind
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("scaled_phase_angle_wrap_core verification failed");
    $finish;
  end

  task automatic add_pair(input logic [15:0] phase, input logic [15:0] amp);
    pair_q.push_back(sample_pair_t'{phase: phase, amp: amp});
  endtask

  // random pairs: marker hits, small values, axis cases and full range
  task automatic queue_random_pairs(input int count, input logic [15:0] marker);
    int          n;
    int          kind;
    logic [15:0] p;
    logic [15:0] a;
    for (n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      p = 16'($urandom);
      a = 16'($urandom);
      if (kind < 10) begin
        p = marker;
        a = marker;
      end else if (kind < 15) begin
        p = marker;
      end else if (kind < 20) begin
        a = marker;
      end else if (kind < 30) begin
        p = 16'($signed($urandom_range(8)) - 4);
        a = 16'($signed($urandom_range(8)) - 4);
      end else if (kind < 35) begin
        a = '0;
      end else if (kind < 38) begin
        p = '0;
      end else if (kind < 46) begin
        // close to the real axis, either side
        p = $urandom_range(1) ? 16'(16'h7FFF - $urandom_range(255))
                              : 16'(16'h8000 + $urandom_range(255));
        a = 16'($signed($urandom_range(6)) - 3);
      end
      add_pair(p, a);
    end
  endtask

  // wait until every expected result has come back, then let the pipe settle
  task automatic drain_pipe();
    do @(posedge clk); while (pair_q.size() != 0 || start || angle_q.size() != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input spaw_reg_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [11:0] gain, input logic [15:0] marker,
                           input int idle, input int count);
    drain_pipe();
    write_reg(REG_IMAG_GAIN, {4'd0, gain});
    write_reg(REG_INVALID_MARKER, marker);
    idle_pct = idle;
    queue_random_pairs(count, marker);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed pairs under reset settings: axes, corners, marker, near-axis wrap
    add_pair(16'h0000, 16'h0000);
    add_pair(16'h7FFF, 16'h0000);
    add_pair(16'h8000, 16'h0000);
    add_pair(16'hFFFF, 16'h0000);
    add_pair(16'h0000, 16'h0001);
    add_pair(16'h0000, 16'hFFFF);
    add_pair(16'h0000, 16'h7FFF);
    add_pair(16'h0000, 16'h8000);
    add_pair(16'h7FFF, 16'h7FFF);
    add_pair(16'h8000, 16'h8000);
    add_pair(16'h8000, 16'h7FFF);
    add_pair(16'h7FFF, 16'h8000);
    add_pair(16'h7FFF, 16'h0001);
    add_pair(16'h7FFF, 16'hFFFF);
    add_pair(16'h8000, 16'h0001);
    add_pair(16'h8000, 16'hFFFF);
    add_pair(16'h0001, 16'h0001);
    add_pair(16'hFFFF, 16'hFFFF);
    add_pair(16'h0001, 16'hFFFF);
    add_pair(16'hFFFF, 16'h0001);
    add_pair(16'h5555, 16'hAAAA);
    add_pair(16'hAAAA, 16'h5555);
    add_pair(16'h8000, 16'h8001);
    add_pair(16'd100, -16'sd37);
    queue_random_pairs(300, 16'h8000);

    // gain and marker extremes, with sender idling varied per phase
    run_phase(12'd4095, 16'h7FFF, 72, 260);
    run_phase(12'd0, 16'h0000, 0, 260);
    run_phase(12'd1, 16'($urandom), 10, 260);
    run_phase(12'd691, 16'h8000, 72, 260);
    run_phase(12'($urandom_range(4095)), 16'($urandom), 10, 260);
    drain_pipe();

    if (mismatch_count == 0 && angle_q.size() == 0)
      $display("scaled_phase_angle_wrap_core verification clean");
    else
      $display("scaled_phase_angle_wrap_core verification failed");
    $finish;
  end

endmodule
